>>> hdl/edfd_pkg.sv
package edfd_pkg;

    typedef struct packed {
        logic [7:0] hall_digit_code;
        logic [7:0] spare_byte_a;
        logic [7:0] spare_byte_b;
        logic [7:0] status_byte_a;
        logic [7:0] high_digit_code;
        logic [7:0] low_digit_code;
        logic [7:0] status_byte_b;
    } frame_t;

    typedef struct packed {
        logic [6:0] third_char;
        logic [6:0] high_char;
        logic [6:0] low_char;
        logic [1:0] direction;
        logic [3:0] fault_status;
        logic       bad_frame;
    } result_t;

    typedef struct packed {
        logic [1:0] direction;
        logic [3:0] fault_status;
    } status_t;

    localparam logic [6:0] UNKNOWN_CHAR = 7'h3F;

    localparam logic [1:0] DIR_IDLE = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;

    localparam logic [3:0] FAULT_NONE   = 4'd0;
    localparam logic [3:0] FAULT_FRD    = 4'd1;
    localparam logic [3:0] FAULT_OLF    = 4'd2;
    localparam logic [3:0] FAULT_EAQ    = 4'd3;
    localparam logic [3:0] FAULT_LOCKED = 4'd4;
    localparam logic [3:0] FAULT_HEL    = 4'd5;
    localparam logic [3:0] FAULT_PRC    = 4'd6;
    localparam logic [3:0] FAULT_OSS    = 4'd7;
    localparam logic [3:0] FAULT_OSI    = 4'd8;
    localparam logic [3:0] FAULT_ATS    = 4'd9;
    localparam logic [3:0] FAULT_BPI    = 4'd10;

endpackage

>>> hdl/edfd_char_decode.sv
module edfd_char_decode (
    input  logic [7:0] code,
    output logic [6:0] ch,
    output logic       unknown
);
    import edfd_pkg::*;

    always_comb
    begin
        unique case (code)
            8'h3F:   ch = 7'h30;
            8'h06:   ch = 7'h31;
            8'h5B:   ch = 7'h32;
            8'h4F:   ch = 7'h33;
            8'h66:   ch = 7'h34;
            8'h6D:   ch = 7'h35;
            8'h7D:   ch = 7'h36;
            8'h07:   ch = 7'h37;
            8'h7F:   ch = 7'h38;
            8'h6F:   ch = 7'h39;
            8'h00:   ch = 7'h20;
            8'h77:   ch = 7'h41;
            8'h91:   ch = 7'h42;
            8'h39:   ch = 7'h43;
            8'h92:   ch = 7'h44;
            8'h79:   ch = 7'h45;
            8'h71:   ch = 7'h46;
            8'h93:   ch = 7'h47;
            8'h76:   ch = 7'h48;
            8'h94:   ch = 7'h49;
            8'h1E:   ch = 7'h4A;
            8'h95:   ch = 7'h4B;
            8'h38:   ch = 7'h4C;
            8'h96:   ch = 7'h4D;
            8'h97:   ch = 7'h4E;
            8'h98:   ch = 7'h4F;
            8'h73:   ch = 7'h50;
            8'h99:   ch = 7'h51;
            8'h9A:   ch = 7'h52;
            8'h9B:   ch = 7'h53;
            8'h9C:   ch = 7'h54;
            8'h3E:   ch = 7'h55;
            8'h9D:   ch = 7'h56;
            8'h9E:   ch = 7'h57;
            8'h9F:   ch = 7'h58;
            8'hA0:   ch = 7'h59;
            8'hA1:   ch = 7'h5A;
            8'h40:   ch = 7'h2D;
            default: ch = UNKNOWN_CHAR;
        endcase
    end

    assign unknown = (ch == UNKNOWN_CHAR);

endmodule

>>> hdl/edfd_status_encode.sv
module edfd_status_encode (
    input  logic [7:0]        status_byte_a,
    input  logic [7:0]        status_byte_b,
    output edfd_pkg::status_t status
);
    import edfd_pkg::*;

    logic [7:0] s3;
    logic [7:0] s6;

    assign s3 = status_byte_a;
    assign s6 = status_byte_b;

    always_comb
    begin
        status.direction    = DIR_IDLE;
        status.fault_status = FAULT_NONE;
        if (!s3[7])
        begin
            // cob board
            priority if (s6[4]) status.direction = DIR_UP;
            else if (s6[5])     status.direction = DIR_DOWN;
            else                status.direction = DIR_IDLE;

            priority if (s6[0]) status.fault_status = FAULT_FRD;
            else if (s6[1])     status.fault_status = FAULT_HEL;
            else if (s6[6])     status.fault_status = FAULT_OLF;
            else if (s6[7])     status.fault_status = FAULT_OSS;
            else if (s3[0])     status.fault_status = FAULT_OSI;
            else if (s3[1])     status.fault_status = FAULT_ATS;
            else if (s3[2])     status.fault_status = FAULT_PRC;
            else if (s3[3])     status.fault_status = FAULT_EAQ;
            else if (s3[6])     status.fault_status = FAULT_LOCKED;
            else                status.fault_status = FAULT_NONE;
        end
        else
        begin
            // fcb board
            priority if (s6[0]) status.direction = DIR_UP;
            else if (s6[1])     status.direction = DIR_DOWN;
            else                status.direction = DIR_IDLE;

            priority if (s3[6]) status.fault_status = FAULT_FRD;
            else if (s6[7])     status.fault_status = FAULT_LOCKED;
            else if (s3[5])     status.fault_status = FAULT_HEL;
            else if (s3[2])     status.fault_status = FAULT_PRC;
            else if (s3[0])     status.fault_status = FAULT_OSI;
            else if (s3[1])     status.fault_status = FAULT_ATS;
            else if (s6[6])     status.fault_status = FAULT_BPI;
            else                status.fault_status = FAULT_NONE;
        end
    end

endmodule

>>> hdl/elevator_display_frame_decoder.sv
// elevator display frame decoder
// frame channel: one seven-byte display frame per transaction (frame_valid,
// frame_stall, frame). result channel: decoded characters, direction, fault
// status and bad_frame flag per transaction (result_valid, result_stall,
// result).
// a frame equal to the last stored good frame gives no result transaction.
// a frame with an unknown digit code gives a result with bad_frame set and
// leaves the stored frame unchanged.
// path: a frame transaction is captured in the input register, then decoded
// into the result register, which drives result_valid.
// throughput: one frame per cycle while frame_stall is low, set by the single
// decode stage between the input register and the result register.
// reset: both stages empty, stored frame all zeros, so an all-zero frame
// right after reset is a duplicate.
// result_stall holds the full result register; the input register keeps taking
// frames until it is full too, then frame_stall rises in the same cycle.
module elevator_display_frame_decoder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               frame_valid,
    output logic               frame_stall,
    input  edfd_pkg::frame_t   frame,
    output logic               result_valid,
    input  logic               result_stall,
    output edfd_pkg::result_t  result
);
    import edfd_pkg::*;

    logic    frame_valid_reg;
    frame_t  frame_reg;
    frame_t  last_frame_reg;
    frame_t  last_frame_next;
    logic    result_valid_reg;
    logic    result_valid_next;
    result_t result_reg;
    result_t result_next;

    logic    advance;
    logic    duplicate;
    logic    fire;
    logic    bad;
    logic    unk_third;
    logic    unk_high;
    logic    unk_low;
    logic [6:0] third_ch;
    logic [6:0] high_ch;
    logic [6:0] low_ch;
    status_t status;

    assign advance     = !result_valid_reg || !result_stall;
    assign frame_stall = frame_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_valid_reg <= 1'b0;
        end
        else if (!frame_stall)
        begin
            frame_valid_reg <= frame_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!frame_stall && frame_valid)
        begin
            frame_reg <= frame;
        end
    end

    edfd_char_decode u_third (
        .code    (frame_reg.hall_digit_code),
        .ch      (third_ch),
        .unknown (unk_third)
    );

    edfd_char_decode u_high (
        .code    (frame_reg.high_digit_code),
        .ch      (high_ch),
        .unknown (unk_high)
    );

    edfd_char_decode u_low (
        .code    (frame_reg.low_digit_code),
        .ch      (low_ch),
        .unknown (unk_low)
    );

    edfd_status_encode u_status (
        .status_byte_a (frame_reg.status_byte_a),
        .status_byte_b (frame_reg.status_byte_b),
        .status        (status)
    );

    assign bad       = unk_third || unk_high || unk_low;
    assign duplicate = (frame_reg == last_frame_reg);
    assign fire      = frame_valid_reg && advance && !duplicate;

    always_comb
    begin
        result_next.third_char   = third_ch;
        result_next.high_char    = high_ch;
        result_next.low_char     = low_ch;
        result_next.bad_frame    = bad;
        result_next.direction    = bad ? DIR_IDLE : status.direction;
        result_next.fault_status = bad ? FAULT_NONE : status.fault_status;

        if (fire)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end

        last_frame_next = (fire && !bad) ? frame_reg : last_frame_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            last_frame_reg   <= '0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            last_frame_reg   <= last_frame_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_store_only_on_good: assert property (
        @(posedge clk) disable iff (!rst_n)
        !$stable(last_frame_reg) |-> $past(fire) && !$past(bad)
    ) else $error("stored frame changed without a good result");

    a_good_result_stored: assert property (
        @(posedge clk) disable iff (!rst_n)
        fire && !bad |=> result_valid && !result.bad_frame
            && last_frame_reg == $past(frame_reg)
    ) else $error("good result not stored");

    a_bad_no_status: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid && result.bad_frame |->
            result.direction == DIR_IDLE && result.fault_status == FAULT_NONE
    ) else $error("bad frame carries status");

    a_stall_needs_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        frame_stall |-> frame_valid_reg && result_valid_reg && result_stall
    ) else $error("frame stalled without a full pipeline");

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import edfd_pkg::*;

    localparam logic [7:0] KNOWN_CODES [38] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F,
        8'h00, 8'h77, 8'h91, 8'h39, 8'h92, 8'h79, 8'h71, 8'h93, 8'h76, 8'h94,
        8'h1E, 8'h95, 8'h38, 8'h96, 8'h97, 8'h98, 8'h73, 8'h99, 8'h9A, 8'h9B,
        8'h9C, 8'h3E, 8'h9D, 8'h9E, 8'h9F, 8'hA0, 8'hA1, 8'h40
    };

    logic    clk;
    logic    rst_n;
    logic    frame_valid;
    logic    frame_stall;
    frame_t  frame_bus;
    logic    result_valid;
    logic    result_stall;
    result_t result_bus;

    int      tx_idle_pct;
    int      rx_idle_pct;
    int      rx_hold_cycles;
    int      mismatch_count;
    frame_t  stored_frame;
    frame_t  last_sent;
    result_t expected_results[$];

    elevator_display_frame_decoder i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame_valid),
        .frame_stall  (frame_stall),
        .frame        (frame_bus),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_bus)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic logic [6:0] seg_to_ascii(input logic [7:0] code);
        case (code)
            8'h3F: return 7'("0");
            8'h06: return 7'("1");
            8'h5B: return 7'("2");
            8'h4F: return 7'("3");
            8'h66: return 7'("4");
            8'h6D: return 7'("5");
            8'h7D: return 7'("6");
            8'h07: return 7'("7");
            8'h7F: return 7'("8");
            8'h6F: return 7'("9");
            8'h00: return 7'(" ");
            8'h77: return 7'("A");
            8'h91: return 7'("B");
            8'h39: return 7'("C");
            8'h92: return 7'("D");
            8'h79: return 7'("E");
            8'h71: return 7'("F");
            8'h93: return 7'("G");
            8'h76: return 7'("H");
            8'h94: return 7'("I");
            8'h1E: return 7'("J");
            8'h95: return 7'("K");
            8'h38: return 7'("L");
            8'h96: return 7'("M");
            8'h97: return 7'("N");
            8'h98: return 7'("O");
            8'h73: return 7'("P");
            8'h99: return 7'("Q");
            8'h9A: return 7'("R");
            8'h9B: return 7'("S");
            8'h9C: return 7'("T");
            8'h3E: return 7'("U");
            8'h9D: return 7'("V");
            8'h9E: return 7'("W");
            8'h9F: return 7'("X");
            8'hA0: return 7'("Y");
            8'hA1: return 7'("Z");
            8'h40: return 7'("-");
            default: return UNKNOWN_CHAR;
        endcase
    endfunction

    task automatic predict_frame(input frame_t f);
        result_t    r;
        logic [1:0] dir;
        logic [3:0] fault;
        logic [7:0] sa;
        logic [7:0] sb;
        if (f == stored_frame)
        begin
            return;
        end
        r = '0;
        r.third_char = seg_to_ascii(f.hall_digit_code);
        r.high_char  = seg_to_ascii(f.high_digit_code);
        r.low_char   = seg_to_ascii(f.low_digit_code);
        if (r.third_char == UNKNOWN_CHAR || r.high_char == UNKNOWN_CHAR ||
            r.low_char == UNKNOWN_CHAR)
        begin
            r.bad_frame = 1'b1;
            expected_results.push_back(r);
            return;
        end
        sa    = f.status_byte_a;
        sb    = f.status_byte_b;
        dir   = DIR_IDLE;
        fault = FAULT_NONE;
        // cob board
        if (!sa[7])
        begin
            if (sb[4])      dir = DIR_UP;
            else if (sb[5]) dir = DIR_DOWN;
            if (sb[0])      fault = FAULT_FRD;
            else if (sb[1]) fault = FAULT_HEL;
            else if (sb[6]) fault = FAULT_OLF;
            else if (sb[7]) fault = FAULT_OSS;
            else if (sa[0]) fault = FAULT_OSI;
            else if (sa[1]) fault = FAULT_ATS;
            else if (sa[2]) fault = FAULT_PRC;
            else if (sa[3]) fault = FAULT_EAQ;
            else if (sa[6]) fault = FAULT_LOCKED;
        end
        // fcb board
        else
        begin
            if (sb[0])      dir = DIR_UP;
            else if (sb[1]) dir = DIR_DOWN;
            if (sa[6])      fault = FAULT_FRD;
            else if (sb[7]) fault = FAULT_LOCKED;
            else if (sa[5]) fault = FAULT_HEL;
            else if (sa[2]) fault = FAULT_PRC;
            else if (sa[0]) fault = FAULT_OSI;
            else if (sa[1]) fault = FAULT_ATS;
            else if (sb[6]) fault = FAULT_BPI;
        end
        r.direction    = dir;
        r.fault_status = fault;
        stored_frame   = f;
        expected_results.push_back(r);
    endtask

    task automatic send_frame(input frame_t f);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            frame_valid <= 1'b0;
            @(posedge clk);
        end
        frame_valid <= 1'b1;
        frame_bus   <= f;
        @(posedge clk);
        while (frame_stall)
        begin
            @(posedge clk);
        end
        predict_frame(f);
        last_sent = f;
    endtask

    function automatic logic [7:0] random_code();
        if ($urandom_range(99) < 92)
        begin
            return KNOWN_CODES[$urandom_range(37)];
        end
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] random_flags();
        case ($urandom_range(3))
            0: return 8'($urandom);
            1: return 8'($urandom & $urandom & $urandom);
            2: return 8'(1 << $urandom_range(7));
            default: return 8'h00;
        endcase
    endfunction

    function automatic frame_t random_frame();
        frame_t f;
        f.hall_digit_code  = random_code();
        f.spare_byte_a     = 8'($urandom);
        f.spare_byte_b     = 8'($urandom);
        f.status_byte_a    = random_flags();
        f.status_byte_a[7] = 1'($urandom);
        f.high_digit_code  = random_code();
        f.low_digit_code   = random_code();
        f.status_byte_b    = random_flags();
        return f;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("mismatch at %0t: %s", $time, msg);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result transaction %h", result_bus));
            end
            else
            begin
                want = expected_results.pop_front();
                if (result_bus.third_char !== want.third_char ||
                    result_bus.high_char !== want.high_char ||
                    result_bus.low_char !== want.low_char ||
                    result_bus.direction !== want.direction ||
                    result_bus.fault_status !== want.fault_status ||
                    result_bus.bad_frame !== want.bad_frame)
                begin
                    report_mismatch($sformatf(
                        "expected chars %h %h %h dir %0d fault %0d bad %b, got %s",
                        want.third_char, want.high_char, want.low_char,
                        want.direction, want.fault_status, want.bad_frame,
                        $sformatf("%h %h %h dir %0d fault %0d bad %b",
                            result_bus.third_char, result_bus.high_char,
                            result_bus.low_char, result_bus.direction,
                            result_bus.fault_status, result_bus.bad_frame)));
                end
            end
        end
    end

    // receiver: random stall, or a long hold-off on request
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_cycles > 0)
            begin
                result_stall   <= 1'b1;
                rx_hold_cycles = rx_hold_cycles - 1;
            end
            else
            begin
                result_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    task automatic test_reset_duplicate();
        send_frame('0);
    endtask

    task automatic test_digit_codes();
        frame_t f;
        for (int i = 0; i < 39; i += 3)
        begin
            f = '0;
            f.hall_digit_code = KNOWN_CODES[i % 38];
            f.high_digit_code = KNOWN_CODES[(i + 1) % 38];
            f.low_digit_code  = KNOWN_CODES[(i + 2) % 38];
            send_frame(f);
        end
    endtask

    task automatic test_unknown_codes();
        frame_t f;
        f = '0;
        f.hall_digit_code = 8'hFF;
        f.high_digit_code = 8'h3F;
        f.low_digit_code  = 8'h06;
        send_frame(f);
        f.hall_digit_code = 8'h06;
        f.high_digit_code = 8'h80;
        send_frame(f);
        f.high_digit_code = 8'h3F;
        f.low_digit_code  = 8'h01;
        f.status_byte_b   = 8'hFF;
        send_frame(f);
        // a bad frame is not stored, so it repeats its result
        send_frame(f);
        // the last good frame is still the stored one
        send_frame(stored_frame);
    endtask

    task automatic test_status_extremes();
        logic [7:0] sa_vals [6] = '{8'h00, 8'h7F, 8'h80, 8'hFF, 8'h80, 8'h7F};
        logic [7:0] sb_vals [6] = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF};
        frame_t     f;
        for (int i = 0; i < 6; i++)
        begin
            f.hall_digit_code = 8'hA1;
            f.spare_byte_a    = (i % 2 == 0) ? 8'hFF : 8'h00;
            f.spare_byte_b    = (i % 2 == 0) ? 8'h00 : 8'hFF;
            f.status_byte_a   = sa_vals[i];
            f.high_digit_code = 8'h7F;
            f.low_digit_code  = 8'h40;
            f.status_byte_b   = sb_vals[i];
            send_frame(f);
        end
    endtask

    task automatic test_random(input int tx_pct, input int rx_pct, input int n_frames);
        frame_t f;
        int     n_new;
        int     pick;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        n_new       = 0;
        while (n_new < n_frames)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
            begin
                f = last_sent;
            end
            else if (pick < 16)
            begin
                f = stored_frame;
            end
            else if (pick < 24)
            begin
                f = stored_frame ^ frame_t'(56'(1) << $urandom_range(55));
            end
            else
            begin
                f = random_frame();
            end
            if (f != stored_frame)
            begin
                n_new++;
            end
            send_frame(f);
        end
    endtask

    task automatic test_backpressure();
        tx_idle_pct    = 0;
        rx_idle_pct    = 0;
        rx_hold_cycles = 80;
        for (int i = 0; i < 16; i++)
        begin
            send_frame(random_frame());
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        frame_valid    = 1'b0;
        frame_bus      = '0;
        tx_idle_pct    = 30;
        rx_idle_pct    = 59;
        rx_hold_cycles = 0;
        mismatch_count = 0;
        stored_frame   = '0;
        last_sent      = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_duplicate();
        test_digit_codes();
        test_unknown_codes();
        test_status_extremes();
        test_random(30, 59, 160);
        test_random(59, 30, 160);
        test_backpressure();
        test_random(0, 0, 160);

        frame_valid <= 1'b0;
        rx_idle_pct = 0;
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> files.f
hdl/edfd_pkg.sv
hdl/edfd_char_decode.sv
hdl/edfd_status_encode.sv
hdl/elevator_display_frame_decoder.sv
verif/tb_top.sv
